[hw/rtl/csb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped sprite blit package
// Shared widths, defaults and the pixel job type passed to the write stage.
// ----------------------------------------------------------------------------
package csb_pkg;

	// Default screen geometry and pixel doubling factors.
	localparam int unsigned SCREEN_WIDTH_DEF  = 320;
	localparam int unsigned SCREEN_HEIGHT_DEF = 200;
	localparam int unsigned X_SCALE_DEF       = 2;
	localparam int unsigned Y_SCALE_DEF       = 2;

	// Framebuffer byte address width.
	localparam int unsigned ADDR_W   = 18;
	localparam int unsigned COLOUR_W = 8;

	// Item codes on the op field.
	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_PIXEL = 1'b1
	} csb_op_t;

	// One drawn pixel: address of its top-left write and its colour.
	typedef struct packed {
		logic [ADDR_W-1:0]   base;
		logic [COLOUR_W-1:0] colour;
	} csb_job_t;

endpackage

[hw/rtl/csb_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped sprite blit write sequencer
// Holds one drawn pixel and expands it into X_SCALE by Y_SCALE byte writes.
// ----------------------------------------------------------------------------
module csb_writer #(
	parameter int unsigned SCREEN_WIDTH = csb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned X_SCALE      = csb_pkg::X_SCALE_DEF,
	parameter int unsigned Y_SCALE      = csb_pkg::Y_SCALE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_push,
	input  csb_pkg::csb_job_t            job_in,
	output logic                         job_stall,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [csb_pkg::ADDR_W-1:0]   write_address,
	output logic [csb_pkg::COLOUR_W-1:0] write_colour,
	output logic                         last_write
);

	// Bytes between two framebuffer rows.
	localparam int unsigned ROW_BYTES = SCREEN_WIDTH * X_SCALE;
	localparam logic [csb_pkg::ADDR_W-1:0] ROW_STEP = csb_pkg::ADDR_W'(ROW_BYTES);
	localparam logic LAST_COL = 1'(X_SCALE - 1);
	localparam logic LAST_ROW = 1'(Y_SCALE - 1);

	logic                         job_valid_s1;
	csb_pkg::csb_job_t            job_s1;
	logic                         sub_col_q;
	logic                         sub_row_q;
	logic                         out_valid_q;
	logic [csb_pkg::ADDR_W-1:0]   addr_q;
	logic [csb_pkg::COLOUR_W-1:0] colour_q;
	logic                         last_q;

	logic                         out_load;
	logic                         at_last_col;
	logic                         at_last_row;
	logic                         job_done;
	logic [csb_pkg::ADDR_W-1:0]   addr_c;

	// The output register takes a new write when it is empty or being taken.
	assign out_load    = job_valid_s1 && (!out_valid_q || !out_stall);
	assign at_last_col = (sub_col_q == LAST_COL);
	assign at_last_row = (sub_row_q == LAST_ROW);
	assign job_done    = out_load && at_last_col && at_last_row;
	assign job_stall   = job_valid_s1 && !job_done;

	// Address of the current sub-write: base, plus a row pitch, plus a column step.
	always_comb begin
		addr_c = job_s1.base + (sub_row_q ? ROW_STEP : '0)
			+ csb_pkg::ADDR_W'(sub_col_q);
	end

	// Job slot and sub-write counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			sub_col_q    <= 1'b0;
			sub_row_q    <= 1'b0;
		end else begin
			if (job_push) begin
				job_valid_s1 <= 1'b1;
			end else if (job_done) begin
				job_valid_s1 <= 1'b0;
			end
			if (out_load) begin
				if (at_last_col) begin
					sub_col_q <= 1'b0;
					sub_row_q <= at_last_row ? 1'b0 : 1'b1;
				end else begin
					sub_col_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			job_s1 <= job_in;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			addr_q   <= addr_c;
			colour_q <= job_s1.colour;
			last_q   <= at_last_col && at_last_row;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = addr_q;
	assign write_colour  = colour_q;
	assign last_write    = last_q;

	// A new pixel only arrives once the slot is free or finishing.
	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_stall)
		else $error("pixel job pushed while the slot is still busy");

	// With no job held the sub-write counters rest at their first write.
	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid_s1 |-> (sub_col_q == 1'b0) && (sub_row_q == 1'b0))
		else $error("sub-write counters not at rest with an empty slot");

	// A finished job leaves the slot empty unless another one replaces it.
	a_slot_frees: assert property (@(posedge clk) disable iff (!arst_n)
		job_done && !job_push |=> !job_valid_s1)
		else $error("job slot still full after its final write");

	// The final write of a job is flagged as last in the output register.
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |=> out_valid_q && last_q)
		else $error("final write of a pixel not marked as last");

endmodule

[hw/rtl/clipped_sprite_blit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped sprite blit
// Colour-keyed sprite blitter with screen clipping and pixel doubling.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries begin items (op = 0),
// which set the sprite position, size and transparent key, and pixel items
// (op = 1), one source pixel each in row order. The output channel
// (out_valid / out_stall) carries framebuffer byte writes.
// A pixel that is on the screen and not keyed becomes X_SCALE * Y_SCALE
// writes; the last of them has last_write set. Begin items, keyed pixels,
// clipped pixels and pixels outside a blit give no writes.
// The first write of a pixel passes through the job slot and then the
// output register before it is presented. Throughput: while the job slot
// is empty, items that give no writes are taken one per cycle. A drawn
// pixel holds the single job slot until its last write has been loaded
// into the output register. Any item that arrives while the slot is
// still busy waits with in_stall high.
// When the receiver stalls, the output register holds its write and the
// job slot stays full, so in_stall stays high until the slot frees.
// Reset clears the blit state, the job slot and the output register; the
// transparent key resets to no key.
// ----------------------------------------------------------------------------
module clipped_sprite_blit #(
	parameter int unsigned SCREEN_WIDTH  = csb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = csb_pkg::SCREEN_HEIGHT_DEF,
	parameter int unsigned X_SCALE       = csb_pkg::X_SCALE_DEF,
	parameter int unsigned Y_SCALE       = csb_pkg::Y_SCALE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic signed [15:0]           dest_x,
	input  logic signed [15:0]           dest_y,
	input  logic [15:0]                  width,
	input  logic [15:0]                  height,
	input  logic signed [8:0]            key_colour,
	input  logic [csb_pkg::COLOUR_W-1:0] pixel_colour,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [csb_pkg::ADDR_W-1:0]   write_address,
	output logic [csb_pkg::COLOUR_W-1:0] write_colour,
	output logic                         last_write
);

	// Screen coordinate widths and the byte pitch of one source row.
	localparam int unsigned XW = $clog2(SCREEN_WIDTH + 1);
	localparam int unsigned YW = $clog2(SCREEN_HEIGHT + 1);
	localparam int unsigned SPRITE_ROW_BYTES = SCREEN_WIDTH * X_SCALE * Y_SCALE;
	localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);

	logic              active_q;
	logic [15:0]       origin_x_q;
	logic [15:0]       origin_y_q;
	logic [15:0]       sprite_width_q;
	logic [15:0]       sprite_height_q;
	logic [15:0]       column_q;
	logic [15:0]       row_q;
	logic [8:0]        key_q;

	logic              in_accept;
	logic              is_pixel;
	logic signed [17:0] sx_c;
	logic signed [17:0] sy_c;
	logic              on_screen;
	logic              keyed;
	logic              draw;
	logic [16:0]       col_next;
	logic [16:0]       row_next;
	logic              job_push;
	logic              job_stall;
	csb_pkg::csb_job_t job_c;

	assign in_stall  = job_stall;
	assign in_accept = in_valid && !in_stall;
	assign is_pixel  = (csb_pkg::csb_op_t'(op) == csb_pkg::OP_PIXEL);

	// Screen position of the current source pixel and the clip and key tests.
	always_comb begin
		sx_c      = $signed({{2{origin_x_q[15]}}, origin_x_q})
			+ $signed({2'b00, column_q});
		sy_c      = $signed({{2{origin_y_q[15]}}, origin_y_q})
			+ $signed({2'b00, row_q});
		on_screen = (sx_c >= 18'sd0) && (sx_c < SW_S)
			&& (sy_c >= 18'sd0) && (sy_c < SH_S);
		keyed     = !key_q[8] && (key_q[7:0] == pixel_colour);
		draw      = active_q && on_screen && !keyed;
		col_next  = {1'b0, column_q} + 17'd1;
		row_next  = {1'b0, row_q} + 17'd1;
	end

	// Byte address of the pixel's top-left write, reduced to the address width.
	always_comb begin
		job_c.base = csb_pkg::ADDR_W'(
			(sy_c[YW-1:0] * SPRITE_ROW_BYTES) + (sx_c[XW-1:0] * X_SCALE));
		job_c.colour = pixel_colour;
	end

	assign job_push = in_accept && is_pixel && draw;

	// Blit state: placement, key and the source pixel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			sprite_width_q  <= '0;
			sprite_height_q <= '0;
			column_q        <= '0;
			row_q           <= '0;
			key_q           <= '1;
		end else if (in_accept) begin
			if (!is_pixel) begin
				origin_x_q      <= dest_x;
				origin_y_q      <= dest_y;
				sprite_width_q  <= width;
				sprite_height_q <= height;
				key_q           <= key_colour;
				column_q        <= '0;
				row_q           <= '0;
				active_q        <= (width != 16'd0) && (height != 16'd0);
			end else if (active_q) begin
				if (col_next >= {1'b0, sprite_width_q}) begin
					column_q <= '0;
					if (row_next >= {1'b0, sprite_height_q}) begin
						row_q    <= '0;
						active_q <= 1'b0;
					end else begin
						row_q <= row_next[15:0];
					end
				end else begin
					column_q <= col_next[15:0];
				end
			end
		end
	end

	csb_writer #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.X_SCALE      (X_SCALE),
		.Y_SCALE      (Y_SCALE)
	) u_writer (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_push      (job_push),
		.job_in        (job_c),
		.job_stall     (job_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_address (write_address),
		.write_colour  (write_colour),
		.last_write    (last_write)
	);

endmodule
